FILE: rtl/core/sgb_pkg.sv
package sgb_pkg;

	localparam int unsigned PIX_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned ACC_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_RADIUS = 3'd2,
		REG_WNEAR = 3'd3,
		REG_WFAR = 3'd4
	} cfg_reg_t;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_FETCH = 1'b1;

	// Control handed from the sequencer to the tap datapath.
	typedef struct packed {
		logic clear;
		logic tap;
		logic last_tap;
	} mac_ctl_t;

	function automatic logic [PIX_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
		logic [ACC_W-1:0] v;
		v = (acc + ACC_W'(32768)) >> 16;
		round_sat = (v > ACC_W'(65535)) ? 16'hFFFF : v[PIX_W-1:0];
	endfunction

endpackage

FILE: rtl/core/sgb_ram.sv
module sgb_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/sgb_mac.sv
module sgb_mac
	import sgb_pkg::*;
(
	input  logic             clk,
	input  mac_ctl_t         ctl,
	input  logic [PIX_W-1:0] pixel,
	input  logic [15:0]      weight,
	output logic [PIX_W-1:0] result
);
	logic [31:0]      prod_s1;
	logic             tap_s1;
	logic             last_s1;
	logic             clear_s1;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] sum;

	always_ff @(posedge clk) begin
		prod_s1 <= pixel * weight;
		tap_s1 <= ctl.tap;
		last_s1 <= ctl.last_tap;
		clear_s1 <= ctl.clear;
	end

	assign sum = (clear_s1 ? '0 : acc_q) + ACC_W'(prod_s1);

	always_ff @(posedge clk) begin
		if (tap_s1) begin
			acc_q <= sum;
		end
		if (tap_s1 && last_s1) begin
			result <= round_sat(sum);
		end
	end
endmodule

FILE: rtl/core/separable_gaussian_blur.sv
// Frame blur engine. Load items (kind 0) write pixels in raster order and
// give no result; the item completing the frame starts the blur, during
// which busy stays high while each pixel of each pass steps through its
// taps, a drain and a write-back, one tap at a time, on the one memory read
// port in use feeding one multiply-accumulate unit. Other loads hold busy
// while the pixel is written. A fetch item (kind 1) gives one result through
// the fetch and output states, marked by done for one cycle; a fetch before
// the frame is complete is answered in the cycle after start with not_ready
// set. The receiver cannot stall, so results must be taken as they come.
module separable_gaussian_blur
	import sgb_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	parameter int unsigned MAX_RADIUS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [PIX_W-1:0]      pixel_in,
	output logic                  done,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  last,
	output logic                  not_ready,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LOAD = 7'b0000010,
		ST_FETCH = 7'b0000100,
		ST_FOUT = 7'b0001000,
		ST_TAP = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_WB = 7'b1000000
	} state_t;

	state_t state_q;
	logic [8:0]  width_q, height_q;
	logic [2:0]  radius_q;
	logic [63:0] wnear_q, wfar_q;
	logic [CW-1:0] load_cnt_q, fetch_cnt_q;
	logic        ready_q;
	logic        pass_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic signed [5:0] k_q;
	logic [1:0]  drain_q;
	logic [PIX_W-1:0] pix_q;

	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;
	logic [3:0]    r_eff;
	logic [CW-1:0] total;
	logic [CW-1:0] fidx;

	always_comb begin
		w_eff = (width_q == 9'd0) ? XW'(1)
			: (32'(width_q) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(width_q);
		h_eff = (height_q == 9'd0) ? YW'(1)
			: (32'(height_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(height_q);
		r_eff = (radius_q == 3'd0) ? 4'd1
			: (32'(radius_q) > MAX_RADIUS) ? 4'(MAX_RADIUS) : {1'b0, radius_q};
	end

	assign total = CW'(w_eff) * CW'(h_eff);
	assign fidx = (fetch_cnt_q >= total) ? '0 : fetch_cnt_q;

	// Tap address: clamp the neighbor coordinate to the frame.
	logic signed [13:0] cx, cy;
	logic [XW-1:0] sx;
	logic [YW-1:0] sy;
	logic [3:0]    off;
	logic [15:0]   weight;
	always_comb begin
		cx = 14'(signed'({1'b0, x_q}));
		cy = 14'(signed'({1'b0, y_q}));
		if (!pass_q) cx = cx + 14'(k_q);
		else cy = cy + 14'(k_q);
		if (cx < 0) sx = '0;
		else if (cx > 14'(w_eff) - 14'sd1) sx = XW'(w_eff - 1'b1);
		else sx = XW'(cx);
		if (cy < 0) sy = '0;
		else if (cy > 14'(h_eff) - 14'sd1) sy = YW'(h_eff - 1'b1);
		else sy = YW'(cy);
		off = k_q[5] ? 4'(-k_q) : 4'(k_q);
		case (off[3:2])
			2'd0: weight = wnear_q[16*off[1:0] +: 16];
			2'd1: weight = wfar_q[16*off[1:0] +: 16];
			default: weight = '0;
		endcase
	end

	logic [CW+XW-1:0] tap_addr_w, out_addr_w;
	assign tap_addr_w = (CW+XW)'(sy) * (CW+XW)'(w_eff) + (CW+XW)'(sx);
	assign out_addr_w = (CW+XW)'(y_q) * (CW+XW)'(w_eff) + (CW+XW)'(x_q);

	logic frame_we, pass_we;
	logic [AW-1:0] frame_waddr, frame_raddr, pass_raddr;
	logic [PIX_W-1:0] frame_wdata, frame_rdata, pass_rdata, mac_res;
	mac_ctl_t mctl;

	always_comb begin
		frame_we = 1'b0;
		frame_waddr = out_addr_w[AW-1:0];
		frame_wdata = mac_res;
		pass_we = 1'b0;
		if (state_q == ST_LOAD && load_cnt_q < CW'(DEPTH)) begin
			frame_we = 1'b1;
			frame_waddr = load_cnt_q[AW-1:0];
			frame_wdata = pix_q;
		end else if (state_q == ST_WB) begin
			frame_we = pass_q;
			pass_we = !pass_q;
		end
		frame_raddr = (state_q == ST_FETCH) ? fidx[AW-1:0] : tap_addr_w[AW-1:0];
		pass_raddr = tap_addr_w[AW-1:0];
	end

	sgb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
		.clk(clk), .we(frame_we), .waddr(frame_waddr), .wdata(frame_wdata),
		.raddr(frame_raddr), .rdata(frame_rdata));
	sgb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pass (
		.clk(clk), .we(pass_we), .waddr(out_addr_w[AW-1:0]), .wdata(mac_res),
		.raddr(pass_raddr), .rdata(pass_rdata));

	// Read data is registered and arrives the cycle after the address; delay tap control to match.
	mac_ctl_t mctl_s1;
	always_comb begin
		mctl.tap = (state_q == ST_TAP);
		mctl.clear = (state_q == ST_TAP) && (k_q == -6'(signed'({2'b0, r_eff})));
		mctl.last_tap = (state_q == ST_TAP) && (k_q == 6'(signed'({2'b0, r_eff})));
	end
	logic [15:0] weight_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mctl_s1 <= '0;
		end else begin
			mctl_s1 <= mctl;
		end
	end
	always_ff @(posedge clk) begin
		weight_s1 <= weight;
	end

	sgb_mac u_mac (
		.clk(clk), .ctl(mctl_s1), .pixel(pass_q ? pass_rdata : frame_rdata),
		.weight(weight_s1), .result(mac_res));

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			radius_q <= 3'd1;
			wnear_q <= 64'd1177121711;
			wfar_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH: width_q <= cfg_data[8:0];
				REG_HEIGHT: height_q <= cfg_data[8:0];
				REG_RADIUS: radius_q <= cfg_data[2:0];
				REG_WNEAR: wnear_q <= cfg_data;
				REG_WFAR: wfar_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pix_q <= pixel_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			load_cnt_q <= '0;
			fetch_cnt_q <= '0;
			ready_q <= 1'b0;
			pass_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			k_q <= '0;
			drain_q <= '0;
			done <= 1'b0;
			pixel_out <= '0;
			last <= 1'b0;
			not_ready <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (kind == KIND_LOAD) begin
							if (ready_q) begin
								ready_q <= 1'b0;
								load_cnt_q <= '0;
								fetch_cnt_q <= '0;
							end
							state_q <= ST_LOAD;
						end else if (!ready_q) begin
							done <= 1'b1;
							pixel_out <= '0;
							last <= 1'b0;
							not_ready <= 1'b1;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_LOAD: begin
					load_cnt_q <= load_cnt_q + 1'b1;
					if (load_cnt_q + 1'b1 >= total) begin
						pass_q <= 1'b0;
						x_q <= '0;
						y_q <= '0;
						k_q <= -6'(signed'({2'b0, r_eff}));
						state_q <= ST_TAP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FETCH: begin
					state_q <= ST_FOUT;
				end
				ST_FOUT: begin
					done <= 1'b1;
					pixel_out <= frame_rdata;
					last <= (fidx == total - 1'b1);
					not_ready <= 1'b0;
					fetch_cnt_q <= (fidx + 1'b1 >= total) ? '0 : fidx + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_TAP: begin
					if (k_q == 6'(signed'({2'b0, r_eff}))) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 6'sd1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd1) state_q <= ST_WB;
				end
				ST_WB: begin
					k_q <= -6'(signed'({2'b0, r_eff}));
					state_q <= ST_TAP;
					if (x_q + 1'b1 < w_eff) begin
						x_q <= x_q + 1'b1;
					end else begin
						x_q <= '0;
						if (y_q + 1'b1 < h_eff) begin
							y_q <= y_q + 1'b1;
						end else begin
							y_q <= '0;
							if (pass_q) begin
								ready_q <= 1'b1;
								fetch_cnt_q <= '0;
								state_q <= ST_IDLE;
							end else begin
								pass_q <= 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> state_q == ST_IDLE) else $error("config taken while busy");
	a_nr_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && not_ready) |-> (pixel_out == '0 && !last)) else $error("bad not-ready item");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |=> !done || !$past(busy)) else $error("done stuck");
	a_fout: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FOUT |=> done && !not_ready) else $error("fetch lost");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TAP |-> x_q < w_eff && y_q < h_eff) else $error("coord out of frame");
`endif
endmodule
